/* design/cpmf_pkg.sv */
`default_nettype none
package cpmf_pkg;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 512;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int CNT_W      = 10;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Constants of the filter
    localparam logic [PIX_W-1:0] FULL_PIXEL  = 8'd255;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 10'd1023;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [WIDTH_W-1:0]   WIDTH_RESET      = 11'd640;
    localparam logic [HEIGHT_W-1:0]  HEIGHT_RESET     = 10'd480;

    // Per-word control flags carried down the pipeline
    typedef struct packed {
        logic load;   // load word (else a read that yields a result)
        logic first;  // load of pixel (0,0)
        logic row0;   // load in the first row
        logic last;   // read of the final pixel of the frame
    } t_item_ctl;

endpackage
`default_nettype wire

/* design/cpmf_ctrl.sv */
`default_nettype none
module cpmf_ctrl
    import cpmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int CW         = 10,
    parameter int RW         = 9,
    parameter int AW         = 19
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic                  i_mode,
    output logic                       o_issue,
    output t_item_ctl                  o_ctl,
    output logic [CW-1:0]              o_col,
    output logic [AW-1:0]              o_addr
);

    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [CW-1:0]       r_lcol, r_rcol;
    logic [RW-1:0]       r_lrow, r_rrow;
    logic [AW-1:0]       r_lbase, r_rbase;
    logic                r_ready;

    logic [CW-1:0] w_wm1;
    logic [RW-1:0] w_hm1;
    logic [31:0]   w_wide_w, w_wide_h;
    logic          w_load, w_lcol_end, w_lrow_end, w_rcol_end, w_rrow_end;

    // Clamp the frame size: zero acts as one, large values saturate
    always_comb begin
        w_wide_w = 32'(r_width);
        w_wide_h = 32'(r_height);
        if (w_wide_w == 32'd0) begin
            w_wm1 = '0;
        end else if (w_wide_w > 32'(MAX_WIDTH)) begin
            w_wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_wm1 = CW'(w_wide_w - 32'd1);
        end
        if (w_wide_h == 32'd0) begin
            w_hm1 = '0;
        end else if (w_wide_h > 32'(MAX_HEIGHT)) begin
            w_hm1 = RW'(MAX_HEIGHT - 1);
        end else begin
            w_hm1 = RW'(w_wide_h - 32'd1);
        end
    end

    assign w_load     = ~i_mode;
    assign w_lcol_end = (r_lcol == w_wm1);
    assign w_lrow_end = (r_lrow == w_hm1);
    assign w_rcol_end = (r_rcol == w_wm1);
    assign w_rrow_end = (r_rrow == w_hm1);

    // Describe the word about to enter the pipeline
    always_comb begin
        o_issue     = i_accept & (w_load | r_ready);
        o_ctl.load  = w_load;
        o_ctl.first = (r_lrow == '0) && (r_lcol == '0);
        o_ctl.row0  = (r_lrow == '0);
        o_ctl.last  = w_rcol_end & w_rrow_end;
        o_col       = w_load ? r_lcol : r_rcol;
        o_addr      = w_load ? (r_lbase + AW'(r_lcol)) : (r_rbase + AW'(r_rcol));
    end

    // Advance the load and read positions; restart them on a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_lcol   <= '0;
            r_lrow   <= '0;
            r_lbase  <= '0;
            r_rcol   <= '0;
            r_rrow   <= '0;
            r_rbase  <= '0;
            r_ready  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= HEIGHT_W'(i_cfg_data);
                default: ;
            endcase
            r_lcol  <= '0;
            r_lrow  <= '0;
            r_lbase <= '0;
            r_rcol  <= '0;
            r_rrow  <= '0;
            r_rbase <= '0;
            r_ready <= 1'b0;
        end else if (i_accept && w_load) begin
            if (o_ctl.first) begin
                r_ready <= 1'b0;
            end
            if (w_lcol_end) begin
                r_lcol <= '0;
                if (w_lrow_end) begin
                    r_lrow  <= '0;
                    r_lbase <= '0;
                    r_ready <= 1'b1;
                    r_rcol  <= '0;
                    r_rrow  <= '0;
                    r_rbase <= '0;
                end else begin
                    r_lrow  <= r_lrow + RW'(1);
                    r_lbase <= r_lbase + ROW_STEP;
                end
            end else begin
                r_lcol <= r_lcol + CW'(1);
            end
        end else if (i_accept && r_ready) begin
            if (w_rcol_end) begin
                r_rcol <= '0;
                if (w_rrow_end) begin
                    r_rrow  <= '0;
                    r_rbase <= '0;
                end else begin
                    r_rrow  <= r_rrow + RW'(1);
                    r_rbase <= r_rbase + ROW_STEP;
                end
            end else begin
                r_rcol <= r_rcol + CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

/* design/cpmf_frame_store.sv */
`default_nettype none
module cpmf_frame_store
    import cpmf_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int AW    = 19
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [PIX_W-1:0] i_wdata,
    output logic      [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    // Write a loaded pixel or fetch a stored one
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* design/cpmf_col_count.sv */
`default_nettype none
module cpmf_col_count
    import cpmf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int CW        = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [CW-1:0]    i_rd_col,
    input  wire logic             i_s2_valid,
    input  wire logic             i_s2_go,
    input  wire t_item_ctl        i_s2_ctl,
    input  wire logic [CW-1:0]    i_s2_col,
    input  wire logic [PIX_W-1:0] i_s2_pix,
    output logic                  o_kept
);

    logic [CNT_W-1:0] r_mem [MAX_WIDTH];
    logic [CNT_W-1:0] r_rdata;
    logic             r_byp;
    logic [CNT_W-1:0] r_bypval;
    logic [CNT_W-1:0] r_max;

    logic [CNT_W-1:0] w_cur;
    logic [CNT_W-1:0] w_cnt;
    logic             w_hit;
    logic             w_wr;

    // Take the freshest count: the word just written ahead, else the memory
    assign w_cur = r_byp ? r_bypval : r_rdata;
    assign w_hit = (i_s2_pix == FULL_PIXEL);
    assign w_wr  = i_s2_go & i_s2_valid & i_s2_ctl.load;

    // First row restarts the count; later rows add and saturate
    always_comb begin
        if (i_s2_ctl.row0) begin
            w_cnt = CNT_W'(w_hit);
        end else if (w_cur == COUNT_LIMIT) begin
            w_cnt = COUNT_LIMIT;
        end else begin
            w_cnt = w_cur + CNT_W'(w_hit);
        end
    end

    assign o_kept = (w_cur >= (r_max >> 2));

    // Update the count memory and fetch the next word's count
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[i_s2_col] <= w_cnt;
        end
        if (i_rd_en) begin
            r_rdata  <= r_mem[i_rd_col];
            r_byp    <= w_wr && (i_s2_col == i_rd_col);
            r_bypval <= w_cnt;
        end
    end

    // Track the running maximum, restarting at the first pixel of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (w_wr && (i_s2_ctl.first || (w_cnt > r_max))) begin
            r_max <= w_cnt;
        end
    end

endmodule
`default_nettype wire

/* design/column_projection_mask_filter.sv */
`default_nettype none
// Column projection mask filter.
// Input words arrive on s_axis: tuser[0] is the mode (0 load, 1 read) and
// tdata[7:0] the pixel of a load word. Loads fill a frame in raster order and
// count, per column, the pixels equal to 255; the first row of each frame
// restarts the counts. Once a full frame has loaded, each read word returns the
// next stored pixel on m_axis, forced to 0 when its column count is below a
// quarter of the largest count. Reads before a frame is ready give nothing.
// The frame size is set through the write port (index 0 width, 1 height); a
// write restarts loading at pixel (0,0). Write only while the block is idle.
// Throughput is one word per cycle while no result is blocked at the output. A
// read word and its addresses are registered in stage 1, the memories answer
// into stage 2, and the result then enters the output register.
// Reset puts the frame size back to 640 x 480, clears the positions, the
// frame-ready flag and the maximum. The stores are not cleared; no sweep runs.
// While the receiver stalls a result holds in the output register and loads
// keep flowing; the input stops once a second read result reaches stage 2,
// with at most one more word held behind it.
module column_projection_mask_filter
    import cpmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] pixel_in
    input  wire logic [0:0]            s_axis_tuser,   // [0] mode
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // [7:0] pixel_out, [8] column_kept
    output logic                       m_axis_tlast    // last_of_frame
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int CW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic             w_accept, w_issue, w_adv, w_s2_res;
    t_item_ctl        w_ctl;
    logic [CW-1:0]    w_col;
    logic [AW-1:0]    w_addr;
    logic [PIX_W-1:0] w_stored;
    logic             w_kept;

    logic             r_s1_v;
    t_item_ctl        r_s1_ctl;
    logic [CW-1:0]    r_s1_col;
    logic [AW-1:0]    r_s1_addr;
    logic [PIX_W-1:0] r_s1_pix;

    logic             r_s2_v;
    t_item_ctl        r_s2_ctl;
    logic [CW-1:0]    r_s2_col;
    logic [PIX_W-1:0] r_s2_pix;

    logic             r_ov;
    logic [PIX_W-1:0] r_opix;
    logic             r_okept;
    logic             r_olast;

    // Advance the whole pipeline unless a result is blocked at the output
    assign w_s2_res      = r_s2_v & ~r_s2_ctl.load;
    assign w_adv         = ~w_s2_res | ~r_ov | m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_accept      = s_axis_tvalid & w_adv;

    cpmf_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW),
        .AW         (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_mode     (s_axis_tuser[0]),
        .o_issue    (w_issue),
        .o_ctl      (w_ctl),
        .o_col      (w_col),
        .o_addr     (w_addr)
    );

    // Stage 1: hold the addressed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ctl  <= w_ctl;
            r_s1_col  <= w_col;
            r_s1_addr <= w_addr;
            r_s1_pix  <= s_axis_tdata;
        end
    end

    cpmf_frame_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_adv & r_s1_v & r_s1_ctl.load),
        .i_re    (w_adv & r_s1_v & ~r_s1_ctl.load),
        .i_addr  (r_s1_addr),
        .i_wdata (r_s1_pix),
        .o_rdata (w_stored)
    );

    // Stage 2: memory data is in; counts are updated and compared here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_ctl <= r_s1_ctl;
            r_s2_col <= r_s1_col;
            r_s2_pix <= r_s1_pix;
        end
    end

    cpmf_col_count #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_count (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_adv & r_s1_v),
        .i_rd_col   (r_s1_col),
        .i_s2_valid (r_s2_v),
        .i_s2_go    (w_adv),
        .i_s2_ctl   (r_s2_ctl),
        .i_s2_col   (r_s2_col),
        .i_s2_pix   (r_s2_pix),
        .o_kept     (w_kept)
    );

    // Output register: load a result word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv && w_s2_res) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_s2_res) begin
            r_opix  <= w_kept ? w_stored : '0;
            r_okept <= w_kept;
            r_olast <= r_s2_ctl.last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_okept, r_opix};
    assign m_axis_tlast  = r_olast;

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import cpmf_pkg::*;

    localparam int unsigned MAX_W        = DEF_MAX_WIDTH;
    localparam int unsigned MAX_H        = DEF_MAX_HEIGHT;
    localparam logic        MODE_LOAD    = 1'b0;
    localparam logic        MODE_READ    = 1'b1;
    localparam int          RANDOM_ITEMS = 150;
    localparam int          DRAIN_LIMIT  = 2000;
    localparam int          PIPE_SETTLE  = 8;
    localparam int          LONG_HOLD    = 300;
    localparam int unsigned SHORT_READS  = 16;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             kept;
        logic             last;
    } t_filt_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] pixel_in
    logic [0:0]            s_axis_tuser;   // [0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;   // [7:0] pixel_out, [8] column_kept
    logic                  m_axis_tlast;

    // Predictor state: stored frame, column counts and positions
    logic [PIX_W-1:0] frame_pixels [int];
    int unsigned      column_hits [MAX_W];
    int unsigned      peak_hits;
    int unsigned      ld_row, ld_col, rd_row, rd_col;
    bit               frame_ready;
    int unsigned      cur_width, cur_height;
    t_filt_result     pending_pixels [$];
    int               loads_taken;
    int               results_due;
    int               mismatches;

    // Stimulus pacing
    int               burst_left;
    bit               idle_on;
    int               stall_request;
    int unsigned      hit_pct [4];

    column_projection_mask_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    // Advance the predictor by one accepted word; queue the filtered pixel of a read
    task automatic mask_filter_update(input logic mode, input logic [PIX_W-1:0] pix);
        int unsigned  w, h, hits;
        t_filt_result res;
        w = clamp_size(cur_width, MAX_W);
        h = clamp_size(cur_height, MAX_H);
        if (ld_col >= w || ld_row >= h) begin
            ld_col = 0;
            ld_row = 0;
        end
        if (rd_col >= w || rd_row >= h) begin
            rd_col = 0;
            rd_row = 0;
        end
        if (mode == MODE_LOAD) begin
            loads_taken++;
            if (ld_row == 0 && ld_col == 0) frame_ready = 1'b0;
            frame_pixels[ld_row * MAX_W + ld_col] = pix;
            hits = (pix == FULL_PIXEL) ? 1 : 0;
            // first row restarts the count, later rows add and saturate
            if (ld_row != 0) begin
                hits += column_hits[ld_col];
                if (hits > COUNT_LIMIT) hits = COUNT_LIMIT;
            end
            column_hits[ld_col] = hits;
            if ((ld_row == 0 && ld_col == 0) || hits > peak_hits) peak_hits = hits;
            ld_col++;
            if (ld_col >= w) begin
                ld_col = 0;
                ld_row++;
                if (ld_row >= h) begin
                    ld_row = 0;
                    frame_ready = 1'b1;
                    rd_row = 0;
                    rd_col = 0;
                end
            end
        end else if (frame_ready) begin
            res.kept  = (column_hits[rd_col] >= (peak_hits >> 2));
            res.pixel = res.kept ? frame_pixels[rd_row * MAX_W + rd_col] : '0;
            res.last  = (rd_row == h - 1 && rd_col == w - 1);
            pending_pixels = {pending_pixels, res};
            results_due++;
            rd_col++;
            if (rd_col >= w) begin
                rd_col = 0;
                rd_row++;
                if (rd_row >= h) rd_row = 0;
            end
        end
    endtask

    // Offer one word in bursts with random gaps; return at the accepting edge
    task automatic send_word(input logic mode, input logic [PIX_W-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = idle_on ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        mask_filter_update(mode, pix);
    endtask

    // Stop offering, wait for the outstanding results and let the pipeline empty
    task automatic drain_results();
        int guard;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        guard = 0;
        while (pending_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            report_mismatch("missing results", 0, pending_pixels.size());
            pending_pixels.delete();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        if (idx == REG_FRAME_WIDTH) cur_width = value & 11'h7FF;
        else cur_height = value & 10'h3FF;
        ld_row = 0;
        ld_col = 0;
        rd_row = 0;
        rd_col = 0;
        frame_ready = 1'b0;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Favour full pixels per column so that some columns fall below the threshold
    function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned col);
        if ($urandom_range(0, 99) < hit_pct[col % 4]) return FULL_PIXEL;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic load_pixels(input int unsigned count, input int unsigned w);
        for (int unsigned p = 0; p < count; p++) send_word(MODE_LOAD, pick_pixel(p % w));
    endtask

    task automatic read_pixels(input int unsigned count);
        repeat (count) send_word(MODE_READ, PIX_W'($urandom_range(0, 255)));
    endtask

    // Compare each delivered pixel with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_filt_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected result pixel_out", m_axis_tdata[7:0], 0);
            end else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[7:0] !== want.pixel)
                    report_mismatch("pixel_out", m_axis_tdata[7:0], want.pixel);
                if (m_axis_tdata[8] !== want.kept)
                    report_mismatch("column_kept", m_axis_tdata[8], want.kept);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_of_frame", m_axis_tlast, want.last);
            end
        end
    end

    // Receiver: rotate a stall pattern, take a long hold-off when asked
    initial begin : rx_pace
        logic [15:0] pattern;
        int          n;
        m_axis_tready <= 1'b0;
        pattern = 16'hFFFF;
        forever begin
            @(posedge i_clk);
            if (stall_request > 0) begin
                n = stall_request;
                stall_request = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            if ($urandom_range(0, 99) == 0)
                pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            pattern = {pattern[14:0], pattern[15]};
            m_axis_tready <= pattern[0];
        end
    end

    // Two columns: one full, one never full and so suppressed; read past the end
    task automatic test_directed();
        set_frame(2, 4);
        idle_on = 1'b1;
        send_word(MODE_READ, 8'hFF);
        send_word(MODE_LOAD, 8'd255);
        send_word(MODE_LOAD, 8'd0);
        send_word(MODE_LOAD, 8'd255);
        send_word(MODE_LOAD, 8'd1);
        send_word(MODE_LOAD, 8'd255);
        send_word(MODE_LOAD, 8'd128);
        send_word(MODE_LOAD, 8'd255);
        send_word(MODE_LOAD, 8'd254);
        read_pixels(9);
        // a new load at the origin drops the ready frame
        send_word(MODE_LOAD, 8'd127);
        send_word(MODE_READ, 8'h00);
        drain_results();
    endtask

    // Register writes restart loading and drop a ready frame
    task automatic test_register_restart();
        hit_pct = '{90, 10, 50, 0};
        set_frame(3, 2);
        load_pixels(4, 3);
        drain_results();
        set_frame(3, 2);
        read_pixels(1);
        load_pixels(6, 3);
        read_pixels(6);
        drain_results();
        set_frame(3, 2);
        read_pixels(2);
        drain_results();
    endtask

    // Zero and oversized registers clamp to one and to the maximum
    task automatic test_size_limits();
        int unsigned sizes [4][2];
        int unsigned w, h, nread;
        sizes = '{'{0, 0}, '{2047, 1}, '{1, 1023}, '{3, 0}};
        hit_pct = '{95, 5, 40, 0};
        idle_on = 1'b0;
        foreach (sizes[i]) begin
            set_frame(sizes[i][0], sizes[i][1]);
            w = clamp_size(sizes[i][0], MAX_W);
            h = clamp_size(sizes[i][1], MAX_H);
            load_pixels(w * h, w);
            // large frames only show that they became ready at the clamped size
            nread = (w * h > SHORT_READS) ? SHORT_READS : w * h + 1;
            read_pixels(nread);
            drain_results();
            idle_on = ~idle_on;
        end
    endtask

    // Hold the receiver off while reads keep coming, so the input backs up
    task automatic test_backpressure();
        hit_pct = '{80, 0, 30, 60};
        idle_on = 1'b0;
        set_frame(4, 4);
        load_pixels(16, 4);
        stall_request = LONG_HOLD;
        read_pixels(40);
        drain_results();
    endtask

    // Random frame sizes, whole frames with random content, some noise and cut-offs
    task automatic test_random_frames();
        int          start;
        int unsigned w, h, npix, nread;
        int unsigned pct_choice [4];
        pct_choice = '{0, 5, 40, 95};
        start = loads_taken + results_due;
        while (loads_taken + results_due - start < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            idle_on = ($urandom_range(0, 3) != 0);
            foreach (hit_pct[k]) hit_pct[k] = pct_choice[$urandom_range(0, 3)];
            set_frame(w, h);
            repeat ($urandom_range(2, 4)) begin
                npix = w * h;
                // now and then break off a frame part way
                if ($urandom_range(0, 7) == 0) npix = $urandom_range(1, npix);
                for (int unsigned p = 0; p < npix; p++) begin
                    if ($urandom_range(0, 15) == 0)
                        send_word(MODE_READ, PIX_W'($urandom_range(0, 255)));
                    send_word(MODE_LOAD, pick_pixel(p % w));
                end
                case ($urandom_range(0, 3))
                    0: nread = $urandom_range(0, w * h);
                    1: nread = w * h + $urandom_range(1, w * h);
                    default: nread = w * h;
                endcase
                for (int unsigned r = 0; r < nread; r++) begin
                    if ($urandom_range(0, 63) == 0) send_word(MODE_LOAD, pick_pixel(r % w));
                    else send_word(MODE_READ, PIX_W'($urandom_range(0, 255)));
                end
            end
            drain_results();
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_FRAME_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_LOAD;
        cur_width     = WIDTH_RESET;
        cur_height    = HEIGHT_RESET;
        peak_hits     = 0;
        ld_row        = 0;
        ld_col        = 0;
        rd_row        = 0;
        rd_col        = 0;
        frame_ready   = 1'b0;
        loads_taken   = 0;
        results_due   = 0;
        mismatches    = 0;
        burst_left    = 0;
        idle_on       = 1'b1;
        stall_request = 0;
        hit_pct       = '{95, 0, 40, 5};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_register_restart();
        test_size_limits();
        test_backpressure();
        test_random_frames();
        drain_results();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/cpmf_pkg.sv
design/cpmf_ctrl.sv
design/cpmf_frame_store.sv
design/cpmf_col_count.sv
design/column_projection_mask_filter.sv
sim/tb.sv
